[hdl/three_level_feedback_scheduler_macros.svh]
// Assertion macros shared by the scheduler modules.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_MACROS_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_MACROS_SVH

`ifndef SYNTH
`define TLFS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");
`define TLFS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");
`else
`define TLFS_ASSERT_IMP(label, clk, rst, ante, cons)
`define TLFS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

[hdl/tlfs_pkg.sv]
package tlfs_pkg;

   localparam int MAX_PROCS  = 16;
   localparam int NUM_LEVELS = 3;
   localparam int SLOT_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W      = $clog2(MAX_PROCS + 1);
   localparam int FQ_DEPTH   = NUM_LEVELS * MAX_PROCS;
   localparam int FQ_AW      = $clog2(FQ_DEPTH);

   localparam int TIME_W  = 32;
   localparam int PID_W   = 8;
   localparam int BURST_W = 16;
   localparam int QUANT_W = 8;
   localparam int USED_W  = 9;
   localparam int LVL_W   = 2;
   localparam int EV_W    = 2;
   localparam int CSR_AW  = 2;
   localparam int CSR_DW  = 32;

   localparam logic [CSR_AW-1:0]  ADDR_BASE_QUANTUM  = '0;
   localparam logic [QUANT_W-1:0] BASE_QUANTUM_RESET = 8'd2;

   localparam logic MODE_ARRIVAL = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   localparam logic [EV_W-1:0] EV_ACCEPT = 2'd0;
   localparam logic [EV_W-1:0] EV_REJECT = 2'd1;
   localparam logic [EV_W-1:0] EV_IDLE   = 2'd2;
   localparam logic [EV_W-1:0] EV_RAN    = 2'd3;

   localparam logic [LVL_W-1:0] LVL_NONE  = 2'd0;
   localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
   localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
   localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

   // queue indexes
   localparam logic [LVL_W-1:0] FIFO_L1 = 2'd0;
   localparam logic [LVL_W-1:0] FIFO_L2 = 2'd1;
   localparam logic [LVL_W-1:0] FIFO_L3 = 2'd2;

   localparam logic [USED_W-1:0] USED_MAX = '1;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [CNT_W:0]     qsum_type;
   typedef logic [CNT_W+1:0]   qtotal_type;
   typedef logic [FQ_AW-1:0]   fq_addr_type;
   typedef logic [LVL_W-1:0]   level_type;
   typedef logic [USED_W-1:0]  used_type;
   typedef logic [TIME_W-1:0]  time_type;

   typedef struct packed {
      logic      push;
      level_type push_idx;
      slot_type  push_slot;
      logic      pop;
      level_type pop_idx;
   } qcmd_type;

   typedef struct packed {
      logic [PID_W-1:0]   pid;
      logic [TIME_W-1:0]  arrival;
      logic [BURST_W-1:0] burst;
      logic [BURST_W-1:0] remaining;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[hdl/three_level_feedback_scheduler.sv]
// Three-level feedback scheduler. An arrival (mode 0) takes the lowest free process slot,
// is stamped with the current time and queued at level 1; a tick (mode 1) demotes or
// requeues the running process, picks the highest nonempty level and runs one unit,
// reporting turnaround and waiting times on completion. Process entries live in one
// single-port-write memory and the three level queues in a second; both reads are registered.
// One transaction is handled at a time. An arrival or an idle tick goes from EXEC back to
// IDLE, a tick that keeps the running process goes through EXEC and RUN (table read, then
// update), and a tick that switches process goes through EXEC, POP and RUN, POP holding the
// queue memory read that precedes the table read. The result is registered as the block
// returns to IDLE and can accept the next transaction. Results sit in an output register,
// so the next transaction is taken while one waits; it then holds in its final state until
// the waiting result is accepted. base_quantum is at byte address 0 of the APB port.
`include "three_level_feedback_scheduler_macros.svh"

module three_level_feedback_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [tlfs_pkg::PID_W-1:0]    req_pid,
   input  logic [tlfs_pkg::BURST_W-1:0]  req_burst,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tlfs_pkg::EV_W-1:0]     rsp_event_res,
   output logic [tlfs_pkg::PID_W-1:0]    rsp_run_pid,
   output logic [tlfs_pkg::LVL_W-1:0]    rsp_run_level,
   output logic [tlfs_pkg::TIME_W-1:0]   rsp_slice_start,
   output logic                          rsp_finished,
   output logic [tlfs_pkg::TIME_W-1:0]   rsp_turnaround,
   output logic [tlfs_pkg::TIME_W-1:0]   rsp_waiting,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tlfs_pkg::CSR_AW-1:0]   paddr,
   input  logic [tlfs_pkg::CSR_DW-1:0]   pwdata,
   output logic [tlfs_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_RUN  = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic                              mode_ff;
   logic [tlfs_pkg::PID_W-1:0]        pid_ff;
   logic [tlfs_pkg::BURST_W-1:0]      burst_ff;
   logic [tlfs_pkg::QUANT_W-1:0]      quantum_ff;
   logic [tlfs_pkg::MAX_PROCS-1:0]    busy_ff, busy_in;
   tlfs_pkg::slot_type                cur_slot_ff, cur_slot_in;
   tlfs_pkg::level_type               cur_level_ff, cur_level_in;
   tlfs_pkg::used_type                used_ff, used_in;
   tlfs_pkg::time_type                now_ff, now_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tlfs_pkg::EV_W-1:0]         rsp_event_ff, res_event;
   logic [tlfs_pkg::PID_W-1:0]        rsp_pid_ff, res_pid;
   logic [tlfs_pkg::LVL_W-1:0]        rsp_level_ff, res_level;
   tlfs_pkg::time_type                rsp_start_ff, res_start;
   logic                              rsp_fin_ff, res_fin;
   tlfs_pkg::time_type                rsp_tat_ff, res_tat;
   tlfs_pkg::time_type                rsp_wait_ff, res_wait;
   logic                              res_load;

   logic                              out_free;
   logic                              free_found;
   tlfs_pkg::slot_type                free_slot;
   logic                              reject;
   logic                              arr_commit;
   logic                              demote1, demote2, preempt2, preempt3;
   logic                              push_en, need_select, pop_en, idle_tick, exec_go;
   tlfs_pkg::level_type               push_idx, pop_idx;
   logic [tlfs_pkg::NUM_LEVELS-1:0]   ne_after;
   logic                              run_fire;
   logic [tlfs_pkg::BURST_W-1:0]      rem_new;
   tlfs_pkg::time_type                now_next, tat;
   logic                              fin;

   tlfs_pkg::qcmd_type                qcmd;
   logic [tlfs_pkg::NUM_LEVELS-1:0]   q_nonempty;
   tlfs_pkg::slot_type                q_pop_slot;

   logic                              tbl_we;
   tlfs_pkg::slot_type                tbl_waddr, tbl_raddr;
   tlfs_pkg::entry_type               tbl_wdata, tbl_rdata;

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = tlfs_pkg::MAX_PROCS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = tlfs_pkg::slot_type'(i);
         end
      end
   end

   assign reject = (burst_ff == '0) || !free_found;

   // feedback and preemption decisions for a tick
   always_comb begin
      demote1  = (cur_level_ff == tlfs_pkg::LVL_ONE)
               && (used_ff >= tlfs_pkg::used_type'(quantum_ff));
      demote2  = (cur_level_ff == tlfs_pkg::LVL_TWO) && (used_ff >= {quantum_ff, 1'b0});
      preempt2 = (cur_level_ff == tlfs_pkg::LVL_TWO) && !demote2 && q_nonempty[0];
      preempt3 = (cur_level_ff == tlfs_pkg::LVL_THREE) && (q_nonempty[0] || q_nonempty[1]);
      push_en  = demote1 || demote2 || preempt2 || preempt3;
      push_idx = (demote1 || preempt2) ? tlfs_pkg::FIFO_L2 : tlfs_pkg::FIFO_L3;
      need_select = (cur_level_ff == tlfs_pkg::LVL_NONE) || push_en;
      for (int k = 0; k < tlfs_pkg::NUM_LEVELS; k++) begin
         ne_after[k] = q_nonempty[k] || (push_en && push_idx == tlfs_pkg::level_type'(k));
      end
      pop_en    = need_select && (|ne_after);
      idle_tick = need_select && !(|ne_after);
      if (ne_after[0]) begin
         pop_idx = tlfs_pkg::FIFO_L1;
      end else if (ne_after[1]) begin
         pop_idx = tlfs_pkg::FIFO_L2;
      end else begin
         pop_idx = tlfs_pkg::FIFO_L3;
      end
      if (mode_ff == tlfs_pkg::MODE_ARRIVAL || idle_tick) begin
         exec_go = out_free;
      end else begin
         exec_go = 1'b1;
      end
   end

   assign arr_commit = (state_ff == S_EXEC) && (mode_ff == tlfs_pkg::MODE_ARRIVAL)
                     && out_free && !reject;
   assign run_fire   = (state_ff == S_RUN) && out_free;

   // one unit of the running process
   always_comb begin
      rem_new  = (tbl_rdata.remaining != '0)
               ? tbl_rdata.remaining - tlfs_pkg::BURST_W'(1)
               : tbl_rdata.remaining;
      now_next = now_ff + tlfs_pkg::time_type'(1);
      fin      = (rem_new == '0);
      tat      = now_next - tbl_rdata.arrival;
   end

   always_comb begin
      qcmd.push      = 1'b0;
      qcmd.push_idx  = tlfs_pkg::FIFO_L1;
      qcmd.push_slot = cur_slot_ff;
      qcmd.pop       = 1'b0;
      qcmd.pop_idx   = pop_idx;
      if (state_ff == S_EXEC) begin
         if (mode_ff == tlfs_pkg::MODE_ARRIVAL) begin
            qcmd.push      = arr_commit;
            qcmd.push_slot = free_slot;
         end else begin
            qcmd.push     = push_en;
            qcmd.push_idx = push_idx;
            qcmd.pop      = pop_en;
         end
      end
   end

   always_comb begin
      tbl_we    = arr_commit || run_fire;
      tbl_waddr = arr_commit ? free_slot : cur_slot_ff;
      tbl_raddr = (state_ff == S_POP) ? q_pop_slot : cur_slot_ff;
      if (arr_commit) begin
         tbl_wdata.pid       = pid_ff;
         tbl_wdata.arrival   = now_ff;
         tbl_wdata.burst     = burst_ff;
         tbl_wdata.remaining = burst_ff;
      end else begin
         tbl_wdata           = tbl_rdata;
         tbl_wdata.remaining = rem_new;
      end
   end

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      cur_slot_in  = cur_slot_ff;
      cur_level_in = cur_level_ff;
      used_in      = used_ff;
      now_in       = now_ff;
      res_load     = 1'b0;
      res_event    = tlfs_pkg::EV_ACCEPT;
      res_pid      = '0;
      res_level    = tlfs_pkg::LVL_NONE;
      res_start    = '0;
      res_fin      = 1'b0;
      res_tat      = '0;
      res_wait     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_go) begin
               if (mode_ff == tlfs_pkg::MODE_ARRIVAL) begin
                  state_in  = S_IDLE;
                  res_load  = 1'b1;
                  res_event = reject ? tlfs_pkg::EV_REJECT : tlfs_pkg::EV_ACCEPT;
                  if (!reject) begin
                     busy_in[free_slot] = 1'b1;
                  end
               end else if (idle_tick) begin
                  state_in     = S_IDLE;
                  res_load     = 1'b1;
                  res_event    = tlfs_pkg::EV_IDLE;
                  res_start    = now_ff;
                  now_in       = now_next;
                  cur_level_in = tlfs_pkg::LVL_NONE;
                  used_in      = '0;
               end else if (pop_en) begin
                  state_in     = S_POP;
                  cur_level_in = pop_idx + tlfs_pkg::LVL_ONE;
                  used_in      = '0;
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_POP: begin
            state_in    = S_RUN;
            cur_slot_in = q_pop_slot;
         end
         S_RUN: begin
            if (out_free) begin
               state_in  = S_IDLE;
               res_load  = 1'b1;
               res_event = tlfs_pkg::EV_RAN;
               res_pid   = tbl_rdata.pid;
               res_level = cur_level_ff;
               res_start = now_ff;
               res_fin   = fin;
               now_in    = now_next;
               used_in   = (used_ff == tlfs_pkg::USED_MAX) ? used_ff
                                                           : used_ff + tlfs_pkg::used_type'(1);
               if (fin) begin
                  res_tat      = tat;
                  res_wait     = tat - tlfs_pkg::time_type'(tbl_rdata.burst);
                  busy_in[cur_slot_ff] = 1'b0;
                  cur_level_in = tlfs_pkg::LVL_NONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = res_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= '0;
         cur_slot_ff  <= '0;
         cur_level_ff <= tlfs_pkg::LVL_NONE;
         used_ff      <= '0;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         quantum_ff   <= tlfs_pkg::BASE_QUANTUM_RESET;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         cur_slot_ff  <= cur_slot_in;
         cur_level_ff <= cur_level_in;
         used_ff      <= used_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && paddr == tlfs_pkg::ADDR_BASE_QUANTUM) begin
            quantum_ff <= pwdata[tlfs_pkg::QUANT_W-1:0];
         end
      end
   end

   // capture the transaction and the result payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         pid_ff   <= req_pid;
         burst_ff <= req_burst;
      end
      if (res_load) begin
         rsp_event_ff <= res_event;
         rsp_pid_ff   <= res_pid;
         rsp_level_ff <= res_level;
         rsp_start_ff <= res_start;
         rsp_fin_ff   <= res_fin;
         rsp_tat_ff   <= res_tat;
         rsp_wait_ff  <= res_wait;
      end
   end

   tlfs_queues u_queues (
      .clock    (clock),
      .reset    (reset),
      .qcmd     (qcmd),
      .nonempty (q_nonempty),
      .pop_slot (q_pop_slot)
   );

   tlfs_ram #(
      .WIDTH (tlfs_pkg::ENTRY_W),
      .DEPTH (tlfs_pkg::MAX_PROCS)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_ff;
   assign rsp_run_pid     = rsp_pid_ff;
   assign rsp_run_level   = rsp_level_ff;
   assign rsp_slice_start = rsp_start_ff;
   assign rsp_finished    = rsp_fin_ff;
   assign rsp_turnaround  = rsp_tat_ff;
   assign rsp_waiting     = rsp_wait_ff;

   assign pready = 1'b1;
   assign prdata = (paddr == tlfs_pkg::ADDR_BASE_QUANTUM)
                 ? tlfs_pkg::CSR_DW'(quantum_ff) : '0;

   `TLFS_ASSERT_IMP(a_run_has_level, clock, reset, state_ff == S_RUN, cur_level_ff != tlfs_pkg::LVL_NONE)
   `TLFS_ASSERT_NXT(a_arrival_takes_slot, clock, reset, arr_commit, $countones(busy_ff) == $countones($past(busy_ff)) + 1)
   `TLFS_ASSERT_NXT(a_finish_frees_slot, clock, reset, run_fire && fin, !busy_ff[$past(cur_slot_ff)] && cur_level_ff == tlfs_pkg::LVL_NONE)

endmodule

[hdl/tlfs_ram.sv]
module tlfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tlfs_queues.sv]
`include "three_level_feedback_scheduler_macros.svh"

module tlfs_queues (
   input  logic                               clock,
   input  logic                               reset,
   input  tlfs_pkg::qcmd_type                 qcmd,
   output logic [tlfs_pkg::NUM_LEVELS-1:0]    nonempty,
   output tlfs_pkg::slot_type                 pop_slot
);

   tlfs_pkg::slot_type    head_ff  [tlfs_pkg::NUM_LEVELS];
   tlfs_pkg::slot_type    head_in  [tlfs_pkg::NUM_LEVELS];
   tlfs_pkg::count_type   count_ff [tlfs_pkg::NUM_LEVELS];
   tlfs_pkg::count_type   count_in [tlfs_pkg::NUM_LEVELS];
   tlfs_pkg::fq_addr_type waddr;
   tlfs_pkg::fq_addr_type raddr;
   tlfs_pkg::qsum_type    tail_sum;
   tlfs_pkg::slot_type    tail;
   tlfs_pkg::slot_type    ram_rdata;
   tlfs_pkg::slot_type    fwd_slot_ff;
   tlfs_pkg::qtotal_type  total;
   logic                  push_here;
   logic                  pop_here;
   logic                  fwd_in;
   logic                  fwd_ff;

   always_comb begin
      waddr     = '0;
      raddr     = '0;
      fwd_in    = 1'b0;
      push_here = 1'b0;
      pop_here  = 1'b0;
      tail_sum  = '0;
      tail      = '0;
      for (int i = 0; i < tlfs_pkg::NUM_LEVELS; i++) begin
         push_here = qcmd.push && (qcmd.push_idx == tlfs_pkg::level_type'(i));
         pop_here  = qcmd.pop && (qcmd.pop_idx == tlfs_pkg::level_type'(i));
         tail_sum  = tlfs_pkg::qsum_type'(head_ff[i]) + tlfs_pkg::qsum_type'(count_ff[i]);
         if (tail_sum >= tlfs_pkg::qsum_type'(tlfs_pkg::MAX_PROCS)) begin
            tail_sum = tail_sum - tlfs_pkg::qsum_type'(tlfs_pkg::MAX_PROCS);
         end
         tail = tlfs_pkg::slot_type'(tail_sum);
         if (push_here) begin
            waddr = tlfs_pkg::fq_addr_type'(i * tlfs_pkg::MAX_PROCS)
                  + tlfs_pkg::fq_addr_type'(tail);
         end
         head_in[i] = head_ff[i];
         if (pop_here) begin
            raddr = tlfs_pkg::fq_addr_type'(i * tlfs_pkg::MAX_PROCS)
                  + tlfs_pkg::fq_addr_type'(head_ff[i]);
            // empty queue refilled and drained in the same cycle: bypass the memory
            if (push_here && count_ff[i] == '0) begin
               fwd_in = 1'b1;
            end
            head_in[i] = (head_ff[i] == tlfs_pkg::slot_type'(tlfs_pkg::MAX_PROCS - 1))
                       ? '0 : head_ff[i] + tlfs_pkg::slot_type'(1);
         end
         count_in[i] = count_ff[i] + tlfs_pkg::count_type'(push_here)
                     - tlfs_pkg::count_type'(pop_here);
         nonempty[i] = (count_ff[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tlfs_pkg::NUM_LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         fwd_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (qcmd.pop) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (qcmd.pop) begin
         fwd_slot_ff <= qcmd.push_slot;
      end
   end

   tlfs_ram #(
      .WIDTH (tlfs_pkg::SLOT_W),
      .DEPTH (tlfs_pkg::FQ_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (qcmd.push),
      .wr_addr (waddr),
      .wr_data (qcmd.push_slot),
      .rd_addr (raddr),
      .rd_data (ram_rdata)
   );

   assign pop_slot = fwd_ff ? fwd_slot_ff : ram_rdata;

   assign total = tlfs_pkg::qtotal_type'(count_ff[0]) + tlfs_pkg::qtotal_type'(count_ff[1])
                + tlfs_pkg::qtotal_type'(count_ff[2]);

   `TLFS_ASSERT_IMP(a_pop_has_entry, clock, reset, qcmd.pop, count_ff[qcmd.pop_idx] != '0 || (qcmd.push && qcmd.push_idx == qcmd.pop_idx))
   `TLFS_ASSERT_IMP(a_push_has_room, clock, reset, qcmd.push, count_ff[qcmd.push_idx] != tlfs_pkg::count_type'(tlfs_pkg::MAX_PROCS))
   `TLFS_ASSERT_IMP(a_total_bounded, clock, reset, 1'b1, total <= tlfs_pkg::qtotal_type'(tlfs_pkg::MAX_PROCS))

endmodule
